### design/tun_pkg.sv
// Package for the triangle unit normal core: widths and the output item type.
// No dependencies.
`timescale 1ns / 1ps
package tun_pkg;
  localparam int unsigned OutWidth = 32;

  typedef struct packed {
    logic                degenerate;
    logic [OutWidth-1:0] normal_z;
    logic [OutWidth-1:0] normal_y;
    logic [OutWidth-1:0] normal_x;
  } tun_out_t;
endpackage

### design/tun_cross.sv
// Edge and cross product stages: edge differences, products and cross differences, each registered.
// Depends on tun_pkg.
`timescale 1ns / 1ps
module tun_cross import tun_pkg::*; #(
  parameter int unsigned CW = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [CW-1:0]      px_i, py_i, pz_i, qx_i, qy_i, qz_i, rx_i, ry_i, rz_i,
  output logic                      valid_o,
  output logic signed [2*CW+2:0]    cx_o, cy_o, cz_o
);
  logic signed [CW:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic v1_q;
  logic signed [2*CW+1:0] m1_q, m2_q, m3_q, m4_q, m5_q, m6_q;
  logic v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q <= {rx_i[CW-1], rx_i} - {qx_i[CW-1], qx_i};
      ay_q <= {ry_i[CW-1], ry_i} - {qy_i[CW-1], qy_i};
      az_q <= {rz_i[CW-1], rz_i} - {qz_i[CW-1], qz_i};
      bx_q <= {px_i[CW-1], px_i} - {qx_i[CW-1], qx_i};
      by_q <= {py_i[CW-1], py_i} - {qy_i[CW-1], qy_i};
      bz_q <= {pz_i[CW-1], pz_i} - {qz_i[CW-1], qz_i};
      m1_q <= ay_q * bz_q;
      m2_q <= az_q * by_q;
      m3_q <= az_q * bx_q;
      m4_q <= ax_q * bz_q;
      m5_q <= ax_q * by_q;
      m6_q <= ay_q * bx_q;
      cx_o <= {m1_q[2*CW+1], m1_q} - {m2_q[2*CW+1], m2_q};
      cy_o <= {m3_q[2*CW+1], m3_q} - {m4_q[2*CW+1], m4_q};
      cz_o <= {m5_q[2*CW+1], m5_q} - {m6_q[2*CW+1], m6_q};
    end
  end
endmodule

### design/tun_norm.sv
// Sum of squares, pipelined integer square root and pipelined restoring dividers.
// Depends on tun_pkg.
`timescale 1ns / 1ps
module tun_norm import tun_pkg::*; #(
  parameter int unsigned CW = 32,
  parameter int unsigned FB = 30
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [2*CW+2:0] cx_i, cy_i, cz_i,
  output logic                   valid_o,
  output tun_out_t               item_o
);
  localparam int unsigned MW = 2*CW + 2;        // magnitude width
  localparam int unsigned HW = MW / 2;          // half magnitude width
  localparam int unsigned SW = 2*MW + 2;        // sum of squares width
  localparam int unsigned RW = SW / 2;          // root width
  localparam int unsigned QW = FB + 2;

  typedef struct packed {
    logic [MW-1:0] mx, my, mz;
    logic          nx, ny, nz;
  } comp_t;

  // stage A: magnitudes
  comp_t ca_q;
  logic  va_q;
  // stage B: partial products of each square, stage C: squares
  logic [MW-1:0]   mag_w [3];
  logic [2*HW-1:0] hh_q [3], hl_q [3], ll_q [3];
  comp_t           cb_q;
  logic            vb_q;
  logic [2*MW-1:0] sq_q [3];
  comp_t           cp_q;
  logic            vp_q;
  // stage D: sum of squares
  logic [SW-1:0] s_q;
  comp_t cc_q;
  logic  vc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vp_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vp_q <= vb_q;
      vc_q <= vp_q;
    end
  end

  always_comb begin
    mag_w[0] = ca_q.mx;
    mag_w[1] = ca_q.my;
    mag_w[2] = ca_q.mz;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_q.nx <= cx_i[MW];
      ca_q.ny <= cy_i[MW];
      ca_q.nz <= cz_i[MW];
      ca_q.mx <= MW'(cx_i[MW] ? -cx_i : cx_i);
      ca_q.my <= MW'(cy_i[MW] ? -cy_i : cy_i);
      ca_q.mz <= MW'(cz_i[MW] ? -cz_i : cz_i);
      for (int k = 0; k < 3; k++) begin
        hh_q[k] <= mag_w[k][MW-1:HW] * mag_w[k][MW-1:HW];
        hl_q[k] <= mag_w[k][MW-1:HW] * mag_w[k][HW-1:0];
        ll_q[k] <= mag_w[k][HW-1:0] * mag_w[k][HW-1:0];
        sq_q[k] <= {hh_q[k], ll_q[k]} + ((2*MW)'(hl_q[k]) << (HW + 1));
      end
      cb_q <= ca_q;
      cp_q <= cb_q;
      s_q  <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      cc_q <= cp_q;
    end
  end

  // square root: one bit per stage, remainder form
  logic [SW-1:0] sr_rem_q  [RW+1];
  logic [SW-1:0] sr_src_q  [RW+1];
  logic [RW-1:0] sr_root_q [RW+1];
  comp_t         sr_c_q    [RW+1];
  logic          sr_z_q    [RW+1];
  logic          sr_v_q    [RW+1];

  always_comb begin
    sr_rem_q[0]  = '0;
    sr_src_q[0]  = s_q;
    sr_root_q[0] = '0;
    sr_c_q[0]    = cc_q;
    sr_z_q[0]    = (s_q == '0);
    sr_v_q[0]    = vc_q;
  end

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    logic [SW-1:0] rem_w, trial_w;
    always_comb begin
      rem_w   = {sr_rem_q[i][SW-3:0], sr_src_q[i][SW-1 -: 2]};
      trial_w = {sr_root_q[i], 2'b01};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sr_v_q[i+1] <= 1'b0;
      else if (en_i) sr_v_q[i+1] <= sr_v_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_src_q[i+1] <= {sr_src_q[i][SW-3:0], 2'b00};
        sr_c_q[i+1]   <= sr_c_q[i];
        sr_z_q[i+1]   <= sr_z_q[i];
        if (rem_w >= trial_w) begin
          sr_rem_q[i+1]  <= rem_w - trial_w;
          sr_root_q[i+1] <= {sr_root_q[i][RW-2:0], 1'b1};
        end else begin
          sr_rem_q[i+1]  <= rem_w;
          sr_root_q[i+1] <= {sr_root_q[i][RW-2:0], 1'b0};
        end
      end
    end
  end

  // division: integer part (two subtract steps), then FB fraction bits
  localparam int unsigned DS = QW;
  localparam int unsigned DW = MW + 2;
  logic [DW-1:0] rx_q [DS+1], ry_q [DS+1], rz_q [DS+1];
  logic [QW-1:0] qx_q [DS+1], qy_q [DS+1], qz_q [DS+1];
  logic [RW-1:0] dm_q [DS+1];
  logic [2:0]    dn_q [DS+1];
  logic          dz_q [DS+1];
  logic          dv_q [DS+1];

  always_comb begin
    rx_q[0] = DW'(sr_c_q[RW].mx);
    ry_q[0] = DW'(sr_c_q[RW].my);
    rz_q[0] = DW'(sr_c_q[RW].mz);
    qx_q[0] = '0;
    qy_q[0] = '0;
    qz_q[0] = '0;
    dm_q[0] = sr_root_q[RW];
    dn_q[0] = {sr_c_q[RW].nz, sr_c_q[RW].ny, sr_c_q[RW].nx};
    dz_q[0] = sr_z_q[RW];
    dv_q[0] = sr_v_q[RW];
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [DW-1:0] ax_w, ay_w, az_w, dd_w;
    always_comb begin
      dd_w = DW'(dm_q[j]);
      if (j < 2) begin
        ax_w = rx_q[j];
        ay_w = ry_q[j];
        az_w = rz_q[j];
      end else begin
        ax_w = {rx_q[j][DW-2:0], 1'b0};
        ay_w = {ry_q[j][DW-2:0], 1'b0};
        az_w = {rz_q[j][DW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[j+1] <= 1'b0;
      else if (en_i) dv_q[j+1] <= dv_q[j];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dm_q[j+1] <= dm_q[j];
        dn_q[j+1] <= dn_q[j];
        dz_q[j+1] <= dz_q[j];
        rx_q[j+1] <= (ax_w >= dd_w) ? ax_w - dd_w : ax_w;
        ry_q[j+1] <= (ay_w >= dd_w) ? ay_w - dd_w : ay_w;
        rz_q[j+1] <= (az_w >= dd_w) ? az_w - dd_w : az_w;
        if (j < 2) begin
          qx_q[j+1] <= qx_q[j] + QW'(ax_w >= dd_w);
          qy_q[j+1] <= qy_q[j] + QW'(ay_w >= dd_w);
          qz_q[j+1] <= qz_q[j] + QW'(az_w >= dd_w);
        end else begin
          qx_q[j+1] <= {qx_q[j][QW-2:0], ax_w >= dd_w};
          qy_q[j+1] <= {qy_q[j][QW-2:0], ay_w >= dd_w};
          qz_q[j+1] <= {qz_q[j][QW-2:0], az_w >= dd_w};
        end
      end
    end
  end

  function automatic logic [OutWidth-1:0] fin(input logic [QW-1:0] q, input logic n,
                                              input logic z);
    logic [QW-1:0] c;
    logic [OutWidth-1:0] e;
    c = (q > (QW'(1) << FB)) ? (QW'(1) << FB) : q;
    e = OutWidth'(c);
    if (z) fin = '0;
    else   fin = n ? -e : e;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (en_i) valid_o <= dv_q[DS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_o.normal_x   <= fin(qx_q[DS], dn_q[DS][0], dz_q[DS]);
      item_o.normal_y   <= fin(qy_q[DS], dn_q[DS][1], dz_q[DS]);
      item_o.normal_z   <= fin(qz_q[DS], dn_q[DS][2], dz_q[DS]);
      item_o.degenerate <= dz_q[DS];
    end
  end
endmodule

### design/triangle_unit_normal_core.sv
// Top level of the triangle unit normal core: stream ports, pipeline, stall logic.
// Depends on tun_pkg, tun_cross and tun_norm.
//
// Usage: s_axis carries one face per item (P, Q, R as signed Q16.16). m_axis
// returns the unit normal in Q1.30 and a degenerate flag for a zero cross product.
// Throughput: one item per cycle unless the output stalls. Stages, in order: edges,
// products and cross differences; magnitudes, partial products, squares and sum of
// squares; a root stage per root bit (2*COORD_WIDTH+3); a divider stage per quotient
// bit (NORMAL_FRAC_BITS+2); the output register. Root and divider stages dominate.
// The whole pipeline advances together when the output register is free or taken;
// when m_axis_tready is low with a result waiting, the pipeline holds and
// s_axis_tready drops, so nothing is lost or repeated.
// Reset clears all valid bits; the block is ready right after reset.
`timescale 1ns / 1ps
module triangle_unit_normal_core import tun_pkg::*; #(
  parameter int unsigned COORD_WIDTH      = 32,
  parameter int unsigned NORMAL_FRAC_BITS = 30
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z, 32 bits each from bit 0
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // normal_x, normal_y, normal_z, degenerate from bit 0, zero fill to 104 bits
  output logic [103:0] m_axis_tdata
);
  localparam int unsigned CW = COORD_WIDTH;
  logic en_w;
  logic v_cross_w;
  logic signed [2*CW+2:0] cx_w, cy_w, cz_w;
  tun_out_t item_w;

  assign en_w          = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en_w;

  function automatic logic signed [CW-1:0] fld(input logic [287:0] d, input int k);
    fld = CW'(d[32*k +: 32]);
  endfunction

  tun_cross #(.CW(CW)) u_cross (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(s_axis_tvalid),
    .px_i(fld(s_axis_tdata, 0)), .py_i(fld(s_axis_tdata, 1)), .pz_i(fld(s_axis_tdata, 2)),
    .qx_i(fld(s_axis_tdata, 3)), .qy_i(fld(s_axis_tdata, 4)), .qz_i(fld(s_axis_tdata, 5)),
    .rx_i(fld(s_axis_tdata, 6)), .ry_i(fld(s_axis_tdata, 7)), .rz_i(fld(s_axis_tdata, 8)),
    .valid_o(v_cross_w), .cx_o(cx_w), .cy_o(cy_w), .cz_o(cz_w)
  );

  tun_norm #(.CW(CW), .FB(NORMAL_FRAC_BITS)) u_norm (
    .clk_i, .rst_ni, .en_i(en_w), .valid_i(v_cross_w),
    .cx_i(cx_w), .cy_i(cy_w), .cz_i(cz_w),
    .valid_o(m_axis_tvalid), .item_o(item_w)
  );

  assign m_axis_tdata = {7'd0, item_w.degenerate, item_w.normal_z, item_w.normal_y,
                         item_w.normal_x};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[96] |-> m_axis_tdata[95:0] == '0)
    else $error("degenerate item with nonzero normal");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("stall coupling broken");
endmodule

### dv/tb.sv
// Testbench for triangle_unit_normal_core: faces in, unit normals checked against a predictor.
// Depends on tun_pkg and the core; bursty sender, random receiver stalls, stall watchdog.
`timescale 1ns / 1ps
module tb;
  import tun_pkg::*;

  localparam int unsigned NormFrac = 30;
  localparam int unsigned StallLimit = 4000;

  class normal_scoreboard;
    tun_out_t normals_q[$];
    int errors;
    int faces;
    int flat_faces;

    function automatic logic signed [191:0] widen(longint v);
      logic signed [191:0] w;
      w = v;
      return w;
    endfunction

    function automatic tun_out_t face_normal(logic [287:0] face);
      longint pt[9];
      longint ea[3], eb[3];
      logic signed [191:0] cr[3];
      logic [191:0] mag, sum_sq, root, cand, quo;
      logic [31:0] comp[3];
      tun_out_t res;
      for (int k = 0; k < 9; k++) pt[k] = longint'($signed(face[32*k +: 32]));
      for (int k = 0; k < 3; k++) begin
        ea[k] = pt[6+k] - pt[3+k];
        eb[k] = pt[k] - pt[3+k];
      end
      cr[0] = widen(ea[1]) * widen(eb[2]) - widen(ea[2]) * widen(eb[1]);
      cr[1] = widen(ea[2]) * widen(eb[0]) - widen(ea[0]) * widen(eb[2]);
      cr[2] = widen(ea[0]) * widen(eb[1]) - widen(ea[1]) * widen(eb[0]);
      sum_sq = '0;
      for (int k = 0; k < 3; k++) sum_sq = sum_sq + cr[k] * cr[k];
      res = '0;
      if (sum_sq == 0) begin
        res.degenerate = 1'b1;
        return res;
      end
      root = '0;
      for (int b = 95; b >= 0; b--) begin
        cand = root | (192'd1 << b);
        if (cand * cand <= sum_sq) root = cand;
      end
      for (int k = 0; k < 3; k++) begin
        mag = (cr[k] < 0) ? -cr[k] : cr[k];
        quo = (mag << NormFrac) / root;
        if (quo > (192'd1 << NormFrac)) quo = 192'd1 << NormFrac;
        comp[k] = (cr[k] < 0) ? -quo[31:0] : quo[31:0];
      end
      res.normal_x = comp[0];
      res.normal_y = comp[1];
      res.normal_z = comp[2];
      return res;
    endfunction

    function void note_face(logic [287:0] face);
      tun_out_t e;
      e = face_normal(face);
      faces++;
      if (e.degenerate) flat_faces++;
      normals_q = {normals_q, e};
    endfunction

    function void check_normal(tun_out_t got);
      tun_out_t e;
      if (normals_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = normals_q.pop_front();
      if (got.normal_x !== e.normal_x) begin
        $display("%0t: normal_x expected %h actual %h", $time, e.normal_x, got.normal_x);
        errors++;
      end
      if (got.normal_y !== e.normal_y) begin
        $display("%0t: normal_y expected %h actual %h", $time, e.normal_y, got.normal_y);
        errors++;
      end
      if (got.normal_z !== e.normal_z) begin
        $display("%0t: normal_z expected %h actual %h", $time, e.normal_z, got.normal_z);
        errors++;
      end
      if (got.degenerate !== e.degenerate) begin
        $display("%0t: degenerate expected %b actual %b", $time, e.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;

  normal_scoreboard sb = new();
  logic [287:0] face_q[$];
  int gap_left = 0;
  int burst_left = 0;
  int stall_cnt = 0;
  int rx_mode_left = 0;
  bit rx_free = 1'b1;

  always #5 clk_i = ~clk_i;

  triangle_unit_normal_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // sender: bursts of items separated by random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_face(s_axis_tdata);
      if (s_axis_tvalid && !s_axis_tready) begin
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (face_q.size() > 0) begin
        s_axis_tdata <= face_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(40, 1);
          gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stretches, each either free-running or with random stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_normal(tun_out_t'(m_axis_tdata[96:0]));
      if (rx_mode_left == 0) begin
        rx_mode_left = $urandom_range(200, 10);
        rx_free = ($urandom_range(2, 0) == 0);
      end
      rx_mode_left--;
      m_axis_tready <= rx_free ? 1'b1 : ($urandom_range(3, 0) != 0);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic logic [287:0] pack_face(logic [31:0] v[9]);
    logic [287:0] f;
    for (int k = 0; k < 9; k++) f[32*k +: 32] = v[k];
    return f;
  endfunction

  function automatic void add_face(logic [287:0] f);
    face_q = {face_q, f};
  endfunction

  function automatic logic [31:0] rand_coord(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000, 0)) - 1000) <<< 16;
      2: return 32'($signed($urandom_range(65535, 0)) - 32768);
      default: begin
        case ($urandom_range(3, 0))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  task automatic queue_random(int n);
    logic [31:0] v[9];
    int kind;
    int t;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(3, 0);
      for (int k = 0; k < 9; k++) v[k] = rand_coord(kind);
      if ($urandom_range(9, 0) == 0) begin
        // collinear: R = Q + t*(P - Q) with small ints, or coincident points
        t = $urandom_range(4, 0) - 2;
        for (int k = 0; k < 3; k++) begin
          v[k] = rand_coord(1);
          v[3+k] = rand_coord(1);
          v[6+k] = v[3+k] + t * (v[k] - v[3+k]);
        end
      end
      add_face(pack_face(v));
    end
  endtask

  task automatic drain();
    while (face_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (sb.normals_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic queue_directed();
    logic [31:0] v[9];
    logic [31:0] ext[4];
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    v = '{default: 32'h0};
    add_face(pack_face(v));
    v = '{32'h10000, 0, 0, 0, 0, 0, 0, 32'h10000, 0};
    add_face(pack_face(v));
    v = '{0, 32'h10000, 0, 0, 0, 0, 0, 0, 32'h10000};
    add_face(pack_face(v));
    v = '{0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 0};
    add_face(pack_face(v));
    v = '{32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 32'h20000, 32'h20000, 32'h20000};
    add_face(pack_face(v));
    v = '{default: 32'h12345678};
    add_face(pack_face(v));
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        if (a != b) begin
          v = '{ext[a], ext[b], ext[a], ext[b], ext[a], ext[b], ext[a], ext[a], ext[b]};
          add_face(pack_face(v));
        end
      end
    end
    v = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
          32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
    add_face(pack_face(v));
    v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000};
    add_face(pack_face(v));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_directed();
    drain();
    queue_random(500);
    drain();
    queue_random(500);
    drain();
    repeat (300) @(posedge clk_i);
    $display("Sent %0d faces, %0d of them degenerate, through bursty input and stalled output.",
             sb.faces, sb.flat_faces);
    $display("Covered axis planes, coordinate extremes, collinear and random faces.");
    if (sb.errors == 0 && sb.normals_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
